@@ src/hfcl_pkg.sv @@
`timescale 1ns / 1ps
// package: shared widths, reset values and register codes of the chunk locator
package hfcl_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int POS_BITS_DEF    = 32;

  localparam int BYTE_BITS      = 8;
  localparam int PATTERN_BITS   = 64;
  localparam int LEN_BITS       = 4;
  localparam int OFFSET_BITS    = 32;
  localparam int CFG_INDEX_BITS = 2;

  // matches held after a byte before the earliest ones are forced out
  localparam int QUEUE_KEEP  = 7;
  localparam int QUEUE_DEPTH = QUEUE_KEEP + 1;

  localparam logic [PATTERN_BITS-1:0] HEADER_PATTERN_RST = 64'h0000_0000_2053_4444;
  localparam logic [LEN_BITS-1:0]     HEADER_LENGTH_RST  = 4'd4;
  localparam logic [PATTERN_BITS-1:0] FOOTER_PATTERN_RST = 64'h0000_0000_3046_4F50;
  localparam logic [LEN_BITS-1:0]     FOOTER_LENGTH_RST  = 4'd4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HEADER_PATTERN = 2'd0,
    REG_HEADER_LENGTH  = 2'd1,
    REG_FOOTER_PATTERN = 2'd2,
    REG_FOOTER_LENGTH  = 2'd3
  } cfg_reg_t;

endpackage

@@ src/hfcl_ifs.sv @@
`timescale 1ns / 1ps
// interfaces: byte stream channel and chunk result channel
interface hfcl_byte_if;
  import hfcl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_byte;
  logic                 stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface hfcl_chunk_if;
  import hfcl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] chunk_start;
  logic [OFFSET_BITS-1:0] chunk_end;
  logic                   run_last;

  modport source (output valid, output chunk_start, output chunk_end, output run_last,
                  input ready);
  modport sink   (input valid, input chunk_start, input chunk_end, input run_last,
                  output ready);
endinterface

@@ src/header_footer_chunk_locator_unit.sv @@
`timescale 1ns / 1ps
// Header/footer chunk locator: takes one stream byte per request and reports
// (chunk_start, chunk_end) pairs, chunk_end exclusive, run_last set on the last pair
// caused by a byte. The byte window is matched against both patterns in the cycle the
// byte is taken; matches go into a header queue and a footer queue, and one retire
// unit takes the earliest held match each cycle, while one is due and the result hold
// has room, and updates the open chunk. A byte therefore holds the input until it has
// retired its matches and, at stream end, closed an open chunk; with equal pattern
// lengths every match retires with its own byte: one byte per cycle is the usual rate.
// Results pass through a one-entry hold (to mark run_last) and a two-entry output
// buffer, so a stalled output holds the byte input only while a byte still has
// matches to retire or a chunk to close.
// Configuration takes effect with the next byte; stream end returns all stream state
// to reset while keeping the configuration.
module header_footer_chunk_locator_unit #(
  parameter int MAX_PATTERN = hfcl_pkg::MAX_PATTERN_DEF,
  parameter int POS_BITS    = hfcl_pkg::POS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [hfcl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hfcl_pkg::PATTERN_BITS-1:0]   cfg_data,
  hfcl_byte_if.sink                           stream,
  hfcl_chunk_if.source                        chunks
);
  import hfcl_pkg::*;

  localparam int LW  = $clog2(MAX_PATTERN + 1);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int TCW = QCW + 1;
  localparam int HDR = 0;
  localparam int FTR = 1;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef struct packed {
    logic [OFFSET_BITS-1:0] chunk_start;
    logic [OFFSET_BITS-1:0] chunk_end;
    logic                   run_last;
  } result_t;

  function automatic logic [LW-1:0] eff_len(input logic [LEN_BITS-1:0] len);
    if (len > LEN_BITS'(MAX_PATTERN)) begin
      return LW'(MAX_PATTERN);
    end
    return LW'(len);
  endfunction

  // configuration registers
  logic [PATTERN_BITS-1:0] header_pattern;
  logic [PATTERN_BITS-1:0] footer_pattern;
  logic [LEN_BITS-1:0]     header_length;
  logic [LEN_BITS-1:0]     footer_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern <= HEADER_PATTERN_RST;
      header_length  <= HEADER_LENGTH_RST;
      footer_pattern <= FOOTER_PATTERN_RST;
      footer_length  <= FOOTER_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEADER_PATTERN: header_pattern <= cfg_data;
        REG_HEADER_LENGTH:  header_length  <= cfg_data[LEN_BITS-1:0];
        REG_FOOTER_PATTERN: footer_pattern <= cfg_data;
        REG_FOOTER_LENGTH:  footer_length  <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- front end
  logic [BYTE_BITS-1:0] hist      [MAX_PATTERN];
  logic [BYTE_BITS-1:0] hist_next [MAX_PATTERN];
  logic [POS_BITS-1:0]  position;
  logic [POS_BITS-1:0]  pos_next;
  logic [POS_BITS-1:0]  hfree;
  logic [POS_BITS-1:0]  ffree;
  logic [LW-1:0]        hl_eff;
  logic [LW-1:0]        fl_eff;
  logic [LW-1:0]        span;
  logic [MAX_PATTERN-1:0] h_eq;
  logic [MAX_PATTERN-1:0] f_eq;
  logic                 h_match;
  logic                 f_match;
  logic                 h_hit;
  logic                 f_hit;
  logic [POS_BITS-1:0]  h_start;
  logic [POS_BITS-1:0]  f_start;
  logic                 span_ok;
  logic [POS_BITS-1:0]  thr;
  logic                 in_acc;

  // context of the byte whose matches are being retired
  logic                 ctx_last;
  logic [POS_BITS-1:0]  ctx_pos;
  logic [POS_BITS-1:0]  ctx_thr;
  logic                 ctx_thr_ok;
  logic [LW-1:0]        ctx_hl;

  assign in_acc = stream.valid && stream.ready;
  assign hl_eff = eff_len(header_length);
  assign fl_eff = eff_len(footer_length);

  // shifted byte window and saturating position
  always_comb begin
    hist_next[0] = stream.data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      hist_next[i] = hist[i-1];
    end
    pos_next = (position == POS_MAX) ? position : position + POS_BITS'(1);
  end

  // window compare for every candidate length
  always_comb begin
    logic h_all;
    logic f_all;
    h_all = 1'b1;
    f_all = 1'b1;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      h_all = 1'b1;
      f_all = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (k < l) begin
          h_all = h_all &&
                  (hist_next[l-1-k] == header_pattern[BYTE_BITS*k +: BYTE_BITS]);
          f_all = f_all &&
                  (hist_next[l-1-k] == footer_pattern[BYTE_BITS*k +: BYTE_BITS]);
        end
      end
      h_eq[l-1] = h_all;
      f_eq[l-1] = f_all;
    end
  end

  // pick the compare of the configured length
  always_comb begin
    h_match = 1'b0;
    f_match = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      if (hl_eff == LW'(l)) begin
        h_match = h_eq[l-1];
      end
      if (fl_eff == LW'(l)) begin
        f_match = f_eq[l-1];
      end
    end
  end

  // new matches that do not overlap the previous one of their kind
  assign h_start = pos_next - POS_BITS'(hl_eff);
  assign f_start = pos_next - POS_BITS'(fl_eff);
  assign h_hit   = h_match && (pos_next >= POS_BITS'(hl_eff)) && (h_start >= hfree);
  assign f_hit   = f_match && (pos_next >= POS_BITS'(fl_eff)) && (f_start >= ffree);

  // retire threshold: a match is due once start + span <= position
  always_comb begin
    span = (hl_eff > fl_eff) ? hl_eff : fl_eff;
    if (span == '0) begin
      span = LW'(1);
    end
  end
  assign span_ok = pos_next >= POS_BITS'(span);
  assign thr     = pos_next - POS_BITS'(span);

  // stream state, cleared when the last byte is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        hist[i] <= '0;
      end
      position <= '0;
      hfree    <= '0;
      ffree    <= '0;
      ctx_last <= 1'b0;
    end else if (in_acc) begin
      ctx_last <= stream.stream_end;
      if (stream.stream_end) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          hist[i] <= '0;
        end
        position <= '0;
        hfree    <= '0;
        ffree    <= '0;
      end else begin
        hist     <= hist_next;
        position <= pos_next;
        if (h_hit) begin
          hfree <= pos_next;
        end
        if (f_hit) begin
          ffree <= pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ctx_pos    <= pos_next;
      ctx_thr    <= thr;
      ctx_thr_ok <= span_ok;
      ctx_hl     <= hl_eff;
    end
  end

  // ---------------------------------------------------------------- match queues
  logic [POS_BITS-1:0] q_pos   [2][QUEUE_DEPTH];
  logic [QCW-1:0]      q_cnt   [2];
  logic [QCW-1:0]      q_widx  [2];
  logic [POS_BITS-1:0] q_wdata [2];
  logic [1:0]          q_push;
  logic [1:0]          q_pop;

  assign q_push[HDR]  = in_acc && h_hit;
  assign q_push[FTR]  = in_acc && f_hit;
  assign q_wdata[HDR] = h_start;
  assign q_wdata[FTR] = f_start;

  always_comb begin
    for (int q = 0; q < 2; q++) begin
      q_widx[q] = q_cnt[q] - QCW'(q_pop[q]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < 2; q++) begin
        q_cnt[q] <= '0;
      end
    end else begin
      for (int q = 0; q < 2; q++) begin
        q_cnt[q] <= q_cnt[q] + QCW'(q_push[q]) - QCW'(q_pop[q]);
      end
    end
  end

  // shift queues: head at entry zero, write behind the last held entry
  always_ff @(posedge clk) begin
    for (int q = 0; q < 2; q++) begin
      if (q_pop[q]) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          q_pos[q][i] <= q_pos[q][i+1];
        end
      end
      if (q_push[q]) begin
        q_pos[q][q_widx[q][QIW-1:0]] <= q_wdata[q];
      end
    end
  end

  // ---------------------------------------------------------------- retire unit
  logic [POS_BITS-1:0] h0, h1, f0, f1;
  logic                hv, fv, h2, f2;
  logic                e_h0, e_h1, e_f0, e_f1;
  logic [TCW-1:0]      q_total;
  logic [TCW-1:0]      total_after;
  logic                pick_f;
  logic [POS_BITS-1:0] head_p;
  logic                evt_work;
  logic                close_work;
  logic                work;
  logic                act_ok;
  logic                act;
  logic                rem_elig;
  logic                more;
  logic                done_after;
  logic [POS_BITS:0]   lim_sum;
  logic                f_late;
  logic                chunk_open;
  logic [POS_BITS-1:0] open_start;
  logic                open_next;
  logic [POS_BITS-1:0] start_next;
  logic                r_new;
  logic [POS_BITS-1:0] r_end;
  logic                can_push;
  logic                hold_valid;

  assign h0 = q_pos[HDR][0];
  assign h1 = q_pos[HDR][1];
  assign f0 = q_pos[FTR][0];
  assign f1 = q_pos[FTR][1];
  assign hv = q_cnt[HDR] != '0;
  assign fv = q_cnt[FTR] != '0;
  assign h2 = q_cnt[HDR] > QCW'(1);
  assign f2 = q_cnt[FTR] > QCW'(1);

  assign e_h0 = ctx_thr_ok && (h0 <= ctx_thr);
  assign e_h1 = ctx_thr_ok && (h1 <= ctx_thr);
  assign e_f0 = ctx_thr_ok && (f0 <= ctx_thr);
  assign e_f1 = ctx_thr_ok && (f1 <= ctx_thr);

  assign q_total     = TCW'(q_cnt[HDR]) + TCW'(q_cnt[FTR]);
  assign total_after = q_total - TCW'(1);

  // earliest held match, header first on a tie
  assign pick_f = fv && (!hv || (f0 < h0));
  assign head_p = pick_f ? f0 : h0;

  assign evt_work   = (hv || fv) &&
                      (ctx_last || (q_total > TCW'(QUEUE_KEEP)) || (hv && e_h0) || (fv && e_f0));
  assign close_work = ctx_last && !hv && !fv && chunk_open;
  assign work       = evt_work || close_work;
  assign act_ok     = !hold_valid || can_push;
  assign act        = work && act_ok;

  assign q_pop[HDR] = act && evt_work && !pick_f;
  assign q_pop[FTR] = act && evt_work && pick_f;

  // a footer closes only when it starts at or after the open header's end
  assign lim_sum = {1'b0, open_start} + (POS_BITS+1)'(ctx_hl);
  assign f_late  = lim_sum[POS_BITS] ? (f0 == POS_MAX) : (f0 >= lim_sum[POS_BITS-1:0]);

  // chunk update for the retired match or the stream-end close
  always_comb begin
    r_new      = 1'b0;
    r_end      = head_p;
    open_next  = chunk_open;
    start_next = open_start;
    if (evt_work) begin
      if (!pick_f) begin
        r_new      = chunk_open;
        open_next  = 1'b1;
        start_next = h0;
      end else begin
        r_new     = chunk_open && f_late;
        open_next = chunk_open && !f_late;
      end
    end else if (close_work) begin
      r_new     = 1'b1;
      r_end     = ctx_pos;
      open_next = 1'b0;
    end
  end

  // lookahead: is anything still due after this retire
  assign rem_elig   = pick_f ? ((f2 && e_f1) || (hv && e_h0)) :
                               ((h2 && e_h1) || (fv && e_f0));
  assign more       = evt_work && (total_after != '0) &&
                      (ctx_last || (total_after > TCW'(QUEUE_KEEP)) || rem_elig);
  assign done_after = !more && !(ctx_last && open_next);

  assign stream.ready = !work || (act && done_after);

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_open <= 1'b0;
    end else if (act) begin
      chunk_open <= open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      open_start <= start_next;
    end
  end

  // ---------------------------------------------------------------- result hold
  logic                   hold_final;
  logic [OFFSET_BITS-1:0] hold_start;
  logic [OFFSET_BITS-1:0] hold_end;
  logic                   hold_out;

  assign hold_out = hold_valid && can_push && (hold_final || (act && r_new));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_final <= 1'b0;
    end else if (act && r_new) begin
      hold_valid <= 1'b1;
      hold_final <= done_after;
    end else if (hold_out) begin
      hold_valid <= 1'b0;
    end else if (act && done_after) begin
      hold_final <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (act && r_new) begin
      hold_start <= OFFSET_BITS'(open_start);
      hold_end   <= OFFSET_BITS'(r_end);
    end
  end

  // ---------------------------------------------------------------- output buffer
  result_t    o_buf [2];
  result_t    o_wdata;
  logic [1:0] o_cnt;
  logic [1:0] o_widx;
  logic       o_pop;

  assign can_push = o_cnt < 2'd2;
  assign o_pop    = chunks.valid && chunks.ready;
  assign o_widx   = o_cnt - 2'(o_pop);
  assign o_wdata  = '{chunk_start: hold_start, chunk_end: hold_end, run_last: hold_final};

  always_ff @(posedge clk) begin
    if (rst) begin
      o_cnt <= '0;
    end else begin
      o_cnt <= o_cnt + 2'(hold_out) - 2'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (o_pop) begin
      o_buf[0] <= o_buf[1];
    end
    if (hold_out) begin
      o_buf[o_widx[0]] <= o_wdata;
    end
  end

  assign chunks.valid       = o_cnt != '0;
  assign chunks.chunk_start = o_buf[0].chunk_start;
  assign chunks.chunk_end   = o_buf[0].chunk_end;
  assign chunks.run_last    = o_buf[0].run_last;

  // ---------------------------------------------------------------- checks
  a_hdr_queue_room: assert property (@(posedge clk) disable iff (rst)
    (q_push[HDR] && !q_pop[HDR]) |-> (q_cnt[HDR] < QCW'(QUEUE_DEPTH)))
    else $error("header match queue overflow");

  a_ftr_queue_room: assert property (@(posedge clk) disable iff (rst)
    (q_push[FTR] && !q_pop[FTR]) |-> (q_cnt[FTR] < QCW'(QUEUE_DEPTH)))
    else $error("footer match queue overflow");

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (act && r_new && hold_valid) |-> hold_out)
    else $error("held result overwritten");

  a_stream_closed: assert property (@(posedge clk) disable iff (rst)
    (!work && ctx_last) |-> (!chunk_open && (q_total == '0)))
    else $error("stream end left a chunk or match behind");

endmodule
